### hdl/vnms_pkg.sv
// ----------------------------------------------------------------------------
// vnms_pkg
// Types, constants and small helpers shared by the vector norm selector.
// ----------------------------------------------------------------------------
package vnms_pkg;

  localparam int MAX_VECTORS = 64;
  localparam int MAX_DIM     = 16;
  localparam int MATRIX_DIM  = 3;

  localparam int COORD_W = 32;
  localparam int NORM_W  = 40;
  localparam int IDX_W   = 6;
  localparam int VCNT_W  = 7;   // holds 0..MAX_VECTORS
  localparam int CCNT_W  = 5;   // holds 0..MAX_DIM
  localparam int ACC_W   = 36;  // sum of MAX_DIM magnitudes of up to 2^31
  localparam int PROD_W  = 64;
  localparam int FORM_W  = 70;
  localparam int RAD_W   = 68;
  localparam int ROOT_W  = 34;
  localparam int REM_W   = 36;
  localparam int NPAIRS  = 6;
  localparam int SQ_STEPS = RAD_W / 2;

  localparam logic [1:0] KIND_MAX    = 2'd0;
  localparam logic [1:0] KIND_SUM    = 2'd1;
  localparam logic [1:0] KIND_MATRIX = 2'd2;

  localparam logic [NORM_W-1:0] TOL_RESET = 40'd6554;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 64;
  localparam logic REG_NORM_KIND = 1'b0;
  localparam logic REG_TOLERANCE = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] coordinate;
    logic                      end_of_vector;
    logic                      end_of_set;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  vector_index;
    logic [NORM_W-1:0] norm_value;
    logic              is_last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_SQLD, ST_SQRT, ST_CLOSE, ST_RD, ST_EVAL, ST_FLUSH
  } state_t;

  typedef struct packed {
    logic             take;
    logic             mul_en;
    logic [2:0]       mul_pair;
    logic             mac_en;
    logic [2:0]       mac_pair;
    logic             sq_load;
    logic             sq_step;
    logic             close;
    logic             rd;
    logic [IDX_W-1:0] rd_addr;
    logic             load_pend;
    logic             push;
    logic             push_last;
    logic             clr_pend;
    logic             end_set;
  } cmd_t;

  typedef struct packed {
    logic              sel;
    logic              pend_v;
    logic              out_free;
    logic [VCNT_W-1:0] vcount;
  } status_t;

  // pairs (j,m) of the upper triangle and their symmetric coefficients
  function automatic logic [1:0] pair_a(input logic [2:0] p);
    case (p)
      3'd0, 3'd1, 3'd2: pair_a = 2'd0;
      3'd3, 3'd4:       pair_a = 2'd1;
      default:          pair_a = 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] pair_b(input logic [2:0] p);
    case (p)
      3'd0:       pair_b = 2'd0;
      3'd1, 3'd3: pair_b = 2'd1;
      default:    pair_b = 2'd2;
    endcase
  endfunction

  function automatic logic signed [FORM_W-1:0] scale_term(input logic [2:0] p,
                                                          input logic signed [PROD_W-1:0] x);
    logic signed [FORM_W-1:0] e;
    e = FORM_W'(x);
    case (p)
      3'd0:       scale_term = e;
      3'd1, 3'd2: scale_term = e + (e <<< 2);
      3'd3, 3'd4: scale_term = e <<< 1;
      default:    scale_term = e + (e <<< 1);
    endcase
  endfunction

endpackage

### hdl/vector_norm_max_select.sv
// ----------------------------------------------------------------------------
// vector_norm_max_select
// Per-vector norms over a set, then the indices whose norm is near the largest.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one signed Q16.16 coordinate per item, with end_of_vector and
//           end_of_set flags (end_of_set also closes the vector).
//   out_* : index and Q24.16 norm of each selected vector, ascending, is_last
//           on the final one of the set.
//   cfg_* : APB-style, norm_kind at 0x0, tolerance at 0x8, 64-bit data.
// Timing:
//   Closing a vector runs a close step for the max and sum norms; the
//   matrix norm first runs 7 form MAC steps, a load and 34 root steps before
//   its close, all on one shared multiplier and root unit.
//   At set end the stored norms are walked one by one, as the norm store is
//   read one entry at a time.
// Reset returns the registers to their reset values and empties the set.
// A stalled receiver holds the output register; the walk then waits on the
// next selected item, and input is refused until the walk has finished.
// ----------------------------------------------------------------------------
module vector_norm_max_select (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  vnms_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output vnms_pkg::out_item_t   out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [3:0]            cfg_paddr,
  input  logic [63:0]           cfg_pwdata,
  output logic [63:0]           cfg_prdata,
  output logic                  cfg_pready
);
  import vnms_pkg::*;

  logic [1:0]        kind_r;
  logic [NORM_W-1:0] tol_r;
  logic              wr_en;
  cmd_t              cmd;
  status_t           sts;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_MAX;
      tol_r  <= TOL_RESET;
    end else if (wr_en) begin
      if (cfg_paddr[3] == REG_NORM_KIND) begin
        kind_r <= cfg_pwdata[1:0];
      end else begin
        tol_r <= cfg_pwdata[NORM_W-1:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[3] == REG_TOLERANCE) ? PDATA_W'(tol_r) : PDATA_W'(kind_r);

  vnms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .eov_in    (in_data.end_of_vector),
    .eos_in    (in_data.end_of_set),
    .norm_kind (kind_r),
    .sts       (sts),
    .cmd       (cmd)
  );

  vnms_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .norm_kind (kind_r),
    .tolerance (tol_r),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### hdl/vnms_ctrl.sv
// ----------------------------------------------------------------------------
// vnms_ctrl
// Sequencer: item intake, quadratic form steps, root steps, close and walk.
// ----------------------------------------------------------------------------
module vnms_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               eov_in,
  input  logic               eos_in,
  input  logic [1:0]         norm_kind,
  input  vnms_pkg::status_t  sts,
  output vnms_pkg::cmd_t     cmd
);
  import vnms_pkg::*;

  state_t            state_r, state_nxt;
  logic [5:0]        step_r, step_nxt;
  logic              eos_r, eos_nxt;
  logic [VCNT_W-1:0] wlk_r, wlk_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      eos_r   <= 1'b0;
      wlk_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      eos_r   <= eos_nxt;
      wlk_r   <= wlk_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    eos_nxt   = eos_r;
    wlk_nxt   = wlk_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.mul_pair = step_r[2:0];
    cmd.mac_pair = 3'(step_r - 6'd1);
    cmd.rd_addr  = wlk_r[IDX_W-1:0];
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          eos_nxt  = eos_in;
          step_nxt = '0;
          if (eov_in || eos_in) begin
            state_nxt = (norm_kind == KIND_MATRIX) ? ST_MUL : ST_CLOSE;
          end
        end
      end
      ST_MUL: begin
        cmd.mul_en = (step_r < 6'(NPAIRS));
        cmd.mac_en = (step_r != 6'd0);
        step_nxt   = step_r + 6'd1;
        if (step_r == 6'(NPAIRS)) begin
          state_nxt = ST_SQLD;
        end
      end
      ST_SQLD: begin
        cmd.sq_load = 1'b1;
        step_nxt    = '0;
        state_nxt   = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sq_step = 1'b1;
        step_nxt    = step_r + 6'd1;
        if (step_r == 6'(SQ_STEPS - 1)) begin
          state_nxt = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        cmd.close = 1'b1;
        wlk_nxt   = '0;
        state_nxt = eos_r ? ST_RD : ST_IDLE;
      end
      ST_RD: begin
        if (wlk_r >= sts.vcount) begin
          state_nxt = ST_FLUSH;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // hold the read data until the pending item can move out
        if (!sts.sel) begin
          wlk_nxt   = wlk_r + 1'b1;
          state_nxt = ST_RD;
        end else if (!sts.pend_v || sts.out_free) begin
          cmd.push      = sts.pend_v;
          cmd.load_pend = 1'b1;
          wlk_nxt       = wlk_r + 1'b1;
          state_nxt     = ST_RD;
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_v) begin
          cmd.end_set = 1'b1;
          state_nxt   = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.push      = 1'b1;
          cmd.push_last = 1'b1;
          cmd.clr_pend  = 1'b1;
          cmd.end_set   = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### hdl/vnms_dp.sv
// ----------------------------------------------------------------------------
// vnms_dp
// Datapath: accumulator, coordinate buffer, form MAC, bitwise root, norm
// store, running maximum and output register.
// ----------------------------------------------------------------------------
module vnms_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  vnms_pkg::in_item_t  in_data,
  input  logic [1:0]          norm_kind,
  input  logic [39:0]         tolerance,
  input  vnms_pkg::cmd_t      cmd,
  output vnms_pkg::status_t   sts,
  output logic                out_valid,
  input  logic                out_ready,
  output vnms_pkg::out_item_t out_data
);
  import vnms_pkg::*;

  logic [ACC_W-1:0]          acc_r;
  logic [CCNT_W-1:0]         cnt_r;
  logic [COORD_W-1:0]        buf_r [MATRIX_DIM];
  logic [VCNT_W-1:0]         vcount_r;
  logic [NORM_W-1:0]         max_r;
  logic [NORM_W-1:0]         store_mem [MAX_VECTORS];
  logic [NORM_W-1:0]         rd_data_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [FORM_W-1:0]  form_r;
  logic [RAD_W-1:0]          rad_r;
  logic [REM_W-1:0]          rem_r;
  logic [ROOT_W-1:0]         root_r;
  logic                      pend_v_r;
  logic [IDX_W-1:0]          pend_idx_r;
  logic [NORM_W-1:0]         pend_norm_r;
  logic                      out_valid_r;
  out_item_t                 out_data_r;

  logic [COORD_W-1:0]        ax;
  logic [REM_W-1:0]          rem_sh, trial;
  logic [NORM_W-1:0]         norm_v;
  logic                      out_free;

  assign ax     = in_data.coordinate[COORD_W-1] ? COORD_W'(-in_data.coordinate)
                                                : in_data.coordinate;
  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1:RAD_W-2]};
  assign trial  = {root_r, 2'b01};
  assign norm_v = (norm_kind == KIND_MATRIX) ? NORM_W'(root_r) : NORM_W'(acc_r);
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      cnt_r    <= '0;
      vcount_r <= '0;
      max_r    <= '0;
      for (int i = 0; i < MATRIX_DIM; i++) begin
        buf_r[i] <= '0;
      end
    end else begin
      if (cmd.take && cnt_r < CCNT_W'(MAX_DIM)) begin
        if (cnt_r < CCNT_W'(MATRIX_DIM)) begin
          buf_r[cnt_r[1:0]] <= in_data.coordinate;
        end
        if (norm_kind == KIND_SUM) begin
          acc_r <= acc_r + ACC_W'(ax);
        end else if (acc_r < ACC_W'(ax)) begin
          acc_r <= ACC_W'(ax);
        end
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.close) begin
        if (vcount_r < VCNT_W'(MAX_VECTORS)) begin
          vcount_r <= vcount_r + 1'b1;
          if (norm_v > max_r) begin
            max_r <= norm_v;
          end
        end
        acc_r <= '0;
        cnt_r <= '0;
        for (int i = 0; i < MATRIX_DIM; i++) begin
          buf_r[i] <= '0;
        end
      end
      if (cmd.end_set) begin
        vcount_r <= '0;
        max_r    <= '0;
      end
    end
  end

  // norm store
  always_ff @(posedge clk) begin
    if (cmd.close && vcount_r < VCNT_W'(MAX_VECTORS)) begin
      store_mem[vcount_r[IDX_W-1:0]] <= norm_v;
    end
    if (cmd.rd) begin
      rd_data_r <= store_mem[cmd.rd_addr];
    end
  end

  // quadratic form and root; unused buffer entries are zero
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      form_r <= '0;
    end
    if (cmd.mul_en) begin
      prod_r <= $signed(buf_r[pair_a(cmd.mul_pair)]) * $signed(buf_r[pair_b(cmd.mul_pair)]);
    end
    if (cmd.mac_en) begin
      form_r <= form_r + scale_term(cmd.mac_pair, prod_r);
    end
    if (cmd.sq_load) begin
      rad_r  <= (!form_r[FORM_W-1] && form_r != '0) ? form_r[RAD_W-1:0] : '0;
      rem_r  <= '0;
      root_r <= '0;
    end
    if (cmd.sq_step) begin
      rad_r <= rad_r << 2;
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // pending item and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_pend) begin
        pend_v_r <= 1'b1;
      end else if (cmd.clr_pend) begin
        pend_v_r <= 1'b0;
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pend) begin
      pend_idx_r  <= cmd.rd_addr;
      pend_norm_r <= rd_data_r;
    end
    if (cmd.push) begin
      out_data_r.vector_index <= pend_idx_r;
      out_data_r.norm_value   <= pend_norm_r;
      out_data_r.is_last      <= cmd.push_last;
    end
  end

  assign sts.sel      = (max_r - rd_data_r) <= tolerance;
  assign sts.pend_v   = pend_v_r;
  assign sts.out_free = out_free;
  assign sts.vcount   = vcount_r;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

endmodule

### hdl/vnms_checker.sv
// ----------------------------------------------------------------------------
// vnms_props
// Port-level checks on the vector norm selector, bound to the top level.
// ----------------------------------------------------------------------------
module vnms_props (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input vnms_pkg::out_item_t out_data,
  input logic                cfg_psel,
  input logic                cfg_penable,
  input logic                cfg_pwrite,
  input logic [3:0]          cfg_paddr,
  input logic [63:0]         cfg_pwdata,
  input logic [63:0]         cfg_prdata,
  input logic                cfg_pready
);
  import vnms_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");

  a_kind_rb: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[3] == REG_NORM_KIND)
    ##1 (cfg_paddr[3] == REG_NORM_KIND)
    |-> cfg_prdata == {62'd0, $past(cfg_pwdata[1:0])})
    else $error("norm_kind readback mismatch");

endmodule

bind vector_norm_max_select vnms_props u_vnms_props (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_data    (out_data),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_paddr   (cfg_paddr),
  .cfg_pwdata  (cfg_pwdata),
  .cfg_prdata  (cfg_prdata),
  .cfg_pready  (cfg_pready)
);
